FILE: sv/npss_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// npss_pkg
// Shared types and constants of the nearest polyline segment search core.
// ----------------------------------------------------------------------------
package npss_pkg;

    localparam int MaxPoints  = 1024;
    localparam int IdxW       = 10;
    localparam int CntW       = 11;
    localparam int UnitW      = 64;
    localparam int DivQBits   = 26;
    localparam int SqrtSteps  = 32;

    localparam logic [1:0] REQ_LOAD   = 2'd0;
    localparam logic [1:0] REQ_WINDOW = 2'd1;
    localparam logic [1:0] REQ_FULL   = 2'd2;

    localparam logic REG_POINT_COUNT   = 1'b0;
    localparam logic REG_SEARCH_RADIUS = 1'b1;

    localparam logic signed [15:0] UNIT_ONE = 16'sd16384;

    typedef enum logic [0:0] {
        OP_DIV,
        OP_SQRT
    } dsu_op_t;

    typedef struct packed {
        logic    start;
        dsu_op_t op;
    } dsu_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } dsu_stat_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_RDA0,
        ST_RDA,
        ST_RDB0,
        ST_RDB,
        ST_MUL,
        ST_DECIDE,
        ST_PROD,
        ST_DIVS,
        ST_DIVW,
        ST_SQ,
        ST_CMP,
        ST_TSQS,
        ST_TSQW,
        ST_TDIVS,
        ST_TDIVW,
        ST_DONE
    } state_t;

endpackage
`default_nettype wire

FILE: sv/npss_divsqrt.sv
`default_nettype none
// ----------------------------------------------------------------------------
// npss_divsqrt
// Shared iterative unit: restoring division or integer square root, one step
// per cycle through a single compare and subtract.
// ----------------------------------------------------------------------------
module npss_divsqrt import npss_pkg::*; (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire dsu_ctrl_t         ctrl,
    input  wire logic [UnitW-1:0]  num,
    input  wire logic [UnitW-1:0]  den,
    output dsu_stat_t              stat,
    output logic [31:0]            result
);

    logic             busy_reg, done_reg;
    dsu_op_t          op_reg;
    logic [5:0]       cnt_reg;
    logic [UnitW-1:0] rem_reg, dsh_reg, r_reg;
    logic [UnitW-1:0] cmp_val;
    logic             ge;

    // In division the comparand is the shifted divisor; in the root it is r + bit.
    assign cmp_val = (op_reg == OP_DIV) ? dsh_reg : (r_reg + dsh_reg);
    assign ge      = (rem_reg >= cmp_val);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (ctrl.start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && cnt_reg == 6'd0) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.start) begin
            op_reg  <= ctrl.op;
            rem_reg <= num;
            r_reg   <= '0;
            if (ctrl.op == OP_DIV) begin
                dsh_reg <= den << (DivQBits - 1);
                cnt_reg <= 6'(DivQBits - 1);
            end else begin
                dsh_reg <= UnitW'(1) << (UnitW - 2);
                cnt_reg <= 6'(SqrtSteps - 1);
            end
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - 6'd1;
            if (ge) begin
                rem_reg <= rem_reg - cmp_val;
            end
            if (op_reg == OP_DIV) begin
                r_reg   <= {r_reg[UnitW-2:0], ge};
                dsh_reg <= dsh_reg >> 1;
            end else begin
                r_reg   <= ge ? ((r_reg >> 1) + dsh_reg) : (r_reg >> 1);
                dsh_reg <= dsh_reg >> 2;
            end
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign result    = r_reg[31:0];

endmodule
`default_nettype wire

FILE: sv/nearest_polyline_segment_search_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nearest_polyline_segment_search_core
// Stores a centreline polyline and finds the segment nearest to a position.
// ----------------------------------------------------------------------------
// Load beats (tuser 0) write one point into the 1024-entry table and produce
// no result. Query beats (tuser 1 windowed, 2 full scan) walk the chosen
// segments one at a time: a segment costs one table read (two for the first),
// four passes through the shared 26x26 multiplier for its length and
// projection, up to two rounded divisions of 26 steps each in the shared
// divide/root unit for the clamped projection, each after two multiplier
// passes for its numerator, and two multiplier passes for the squared
// distance. After the walk the tangent of the winning segment takes a 32-step
// square root and two more divisions. The input is not ready while a query is
// in progress; one finished result may wait in the output register while the
// next beat is taken. Table entries never loaded read back as anything, so
// queries must only cover loaded points. Fewer than two points answer "not found".
// ----------------------------------------------------------------------------
module nearest_polyline_segment_search_core import npss_pkg::*; (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    // Configuration write port
    input  wire logic         cfg_wen,
    input  wire logic         cfg_addr,
    input  wire logic [10:0]  cfg_wdata,
    // Input stream
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // entry_idx[9:0], point_x[25:10], point_y[41:26], pos_x[65:42],
    // pos_y[89:66], last_segment[99:90], zero fill above
    input  wire logic [103:0] s_tdata,
    // req_type[1:0]
    input  wire logic [1:0]   s_tuser,
    // Result stream
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // found[0], segment[10:1], closest_x[34:11], closest_y[58:35],
    // tangent_x[74:59], tangent_y[90:75], zero fill above
    output logic [95:0]       m_tdata
);

    // Configuration registers.
    logic [CntW-1:0] point_count_reg;
    logic [IdxW-1:0] search_radius_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            point_count_reg   <= '0;
            search_radius_reg <= 10'd5;
        end else if (cfg_wen) begin
            unique case (cfg_addr)
                REG_POINT_COUNT:   point_count_reg   <= cfg_wdata;
                REG_SEARCH_RADIUS: search_radius_reg <= cfg_wdata[IdxW-1:0];
                default: ;
            endcase
        end
    end

    // Input field views.
    logic [IdxW-1:0]    in_index, in_last;
    logic signed [15:0] in_px, in_py;
    logic               in_accept;

    assign in_index  = s_tdata[9:0];
    assign in_px     = s_tdata[25:10];
    assign in_py     = s_tdata[41:26];
    assign in_last   = s_tdata[99:90];
    assign in_accept = s_tvalid && s_tready;

    // Point table: x in the low half, y in the high half.
    logic [31:0]     mem [MaxPoints];
    logic [IdxW-1:0] addr_reg;
    logic [31:0]     rdata_reg;

    always_ff @(posedge aclk) begin
        if (in_accept && s_tuser == REQ_LOAD) begin
            mem[in_index] <= {in_py, in_px};
        end
        rdata_reg <= mem[addr_reg];
    end

    // Window bounds worked out at accept time.
    logic [CntW-1:0] cnt_eff, hi_full, win_sum;
    logic [IdxW-1:0] hi0, ctr, lo_win, hi_win;

    always_comb begin
        cnt_eff = (point_count_reg > CntW'(MaxPoints)) ? CntW'(MaxPoints) : point_count_reg;
        hi_full = cnt_eff - CntW'(2);
        hi0     = hi_full[IdxW-1:0];
        ctr     = (in_last > hi0) ? hi0 : in_last;
        lo_win  = (ctr > search_radius_reg) ? (ctr - search_radius_reg) : '0;
        win_sum = {1'b0, ctr} + {1'b0, search_radius_reg};
        hi_win  = (win_sum < {1'b0, hi0}) ? win_sum[IdxW-1:0] : hi0;
    end

    // Sequencer and datapath registers.
    state_t state_reg, state_next;
    logic [1:0]  k_reg;
    logic        axis_reg;
    logic [IdxW-1:0] seg_reg, hi_reg;
    logic signed [23:0] px_reg, py_reg;
    logic signed [15:0] ax_reg, ay_reg, bx_reg, by_reg;
    logic signed [16:0] abx_reg, aby_reg;
    logic signed [24:0] apx_reg, apy_reg;
    logic [33:0]        len_reg;
    logic signed [42:0] dot_reg;
    logic signed [60:0] num_reg;
    logic signed [24:0] cx_reg, cy_reg;
    logic [50:0]        dist_reg;
    logic               found_reg;
    logic [IdxW-1:0]    best_seg_reg;
    logic [50:0]        best_dist_reg;
    logic signed [24:0] best_cx_reg, best_cy_reg;
    logic signed [16:0] best_abx_reg, best_aby_reg;
    logic [33:0]        best_len_reg;
    logic [31:0]        s_root_reg;
    logic signed [15:0] tx_reg, ty_reg;
    logic               m_valid_reg;
    logic [95:0]        m_data_reg;

    // Shared multiplier.
    logic signed [25:0] mul_a, mul_b;
    logic signed [51:0] prod;
    logic signed [25:0] dx, dy;
    logic signed [16:0] ab_axis;

    assign dx      = 26'(px_reg) - 26'(cx_reg);
    assign dy      = 26'(py_reg) - 26'(cy_reg);
    assign ab_axis = axis_reg ? aby_reg : abx_reg;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        if (state_reg == ST_MUL) begin
            case (k_reg)
                2'd0: begin mul_a = 26'(abx_reg); mul_b = 26'(abx_reg); end
                2'd1: begin mul_a = 26'(aby_reg); mul_b = 26'(aby_reg); end
                2'd2: begin mul_a = 26'(apx_reg); mul_b = 26'(abx_reg); end
                default: begin mul_a = 26'(apy_reg); mul_b = 26'(aby_reg); end
            endcase
        end else if (state_reg == ST_PROD) begin
            // Projection times direction, split into low and high parts of the dot.
            mul_a = k_reg[0] ? 26'(dot_reg[42:21]) : 26'($signed({1'b0, dot_reg[20:0]}));
            mul_b = 26'(ab_axis);
        end else if (state_reg == ST_SQ) begin
            mul_a = k_reg[0] ? dy : dx;
            mul_b = k_reg[0] ? dy : dx;
        end
    end

    assign prod = mul_a * mul_b;

    // Divide and root unit.
    dsu_ctrl_t        dsu_ctrl;
    dsu_stat_t        dsu_stat;
    logic [UnitW-1:0] dsu_num, dsu_den;
    logic [31:0]      dsu_result;
    logic [59:0]      num_mag;
    logic [44:0]      tan_mag;
    logic signed [16:0] best_ab_axis;

    assign num_mag      = num_reg[60] ? 60'(-num_reg) : num_reg[59:0];
    assign best_ab_axis = axis_reg ? best_aby_reg : best_abx_reg;
    assign tan_mag      = {(best_ab_axis[16] ? 17'(-best_ab_axis) : best_ab_axis), 28'b0};

    always_comb begin
        dsu_ctrl.start = 1'b0;
        dsu_ctrl.op    = OP_DIV;
        dsu_num        = '0;
        dsu_den        = '0;
        unique case (state_reg)
            ST_DIVS: begin
                // Round to nearest, halves away from zero: (2m + L) / (2L).
                dsu_ctrl.start = 1'b1;
                dsu_num = UnitW'({num_mag, 1'b0}) + UnitW'(len_reg);
                dsu_den = UnitW'({len_reg, 1'b0});
            end
            ST_TSQS: begin
                dsu_ctrl.start = (best_len_reg != '0);
                dsu_ctrl.op    = OP_SQRT;
                dsu_num        = UnitW'({best_len_reg, 28'b0});
            end
            ST_TDIVS: begin
                dsu_ctrl.start = 1'b1;
                dsu_num = UnitW'({tan_mag, 1'b0}) + UnitW'(s_root_reg);
                dsu_den = UnitW'({s_root_reg, 1'b0});
            end
            default: ;
        endcase
    end

    npss_divsqrt u_divsqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (dsu_ctrl),
        .num     (dsu_num),
        .den     (dsu_den),
        .stat    (dsu_stat),
        .result  (dsu_result)
    );

    // Next state.
    logic dot_nonpos, dot_past_end, out_free;

    assign dot_nonpos   = dot_reg[42] || (dot_reg == '0);
    assign dot_past_end = ($unsigned(dot_reg[41:0]) >= {len_reg, 8'b0});
    assign out_free     = !m_valid_reg || m_tready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_accept && (s_tuser == REQ_WINDOW || s_tuser == REQ_FULL)) begin
                    state_next = (cnt_eff < CntW'(2)) ? ST_DONE : ST_RDA0;
                end
            end
            ST_RDA0:   state_next = ST_RDA;
            ST_RDA:    state_next = ST_RDB0;
            ST_RDB0:   state_next = ST_RDB;
            ST_RDB:    state_next = ST_MUL;
            ST_MUL:    state_next = (k_reg == 2'd3) ? ST_DECIDE : ST_MUL;
            ST_DECIDE: begin
                if (len_reg == '0 || dot_nonpos || dot_past_end) begin
                    state_next = ST_SQ;
                end else begin
                    state_next = ST_PROD;
                end
            end
            ST_PROD:   state_next = k_reg[0] ? ST_DIVS : ST_PROD;
            ST_DIVS:   state_next = ST_DIVW;
            ST_DIVW: begin
                if (dsu_stat.done) begin
                    state_next = axis_reg ? ST_SQ : ST_PROD;
                end
            end
            ST_SQ:     state_next = k_reg[0] ? ST_CMP : ST_SQ;
            ST_CMP:    state_next = (seg_reg == hi_reg) ? ST_TSQS : ST_RDB0;
            ST_TSQS:   state_next = (best_len_reg == '0) ? ST_DONE : ST_TSQW;
            ST_TSQW:   state_next = dsu_stat.done ? ST_TDIVS : ST_TSQW;
            ST_TDIVS:  state_next = ST_TDIVW;
            ST_TDIVW: begin
                if (dsu_stat.done) begin
                    state_next = axis_reg ? ST_DONE : ST_TDIVS;
                end
            end
            ST_DONE:   state_next = out_free ? ST_IDLE : ST_DONE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Rounded quotient with the sign of the direction, and clamped tangent.
    logic signed [25:0] q_signed;
    logic [14:0]        t_mag_low;
    logic [15:0]        t_mag;
    logic signed [15:0] t_val;

    assign q_signed  = ab_axis[16] ? -$signed({2'b0, dsu_result[23:0]})
                                   :  $signed({2'b0, dsu_result[23:0]});
    assign t_mag_low = dsu_result[14:0];
    assign t_mag     = (dsu_result > 32'd16384) ? 16'd16384 : {1'b0, t_mag_low};
    assign t_val     = best_ab_axis[16] ? -$signed(t_mag) : $signed(t_mag);

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                k_reg     <= '0;
                addr_reg  <= (s_tuser == REQ_WINDOW) ? lo_win : '0;
                seg_reg   <= (s_tuser == REQ_WINDOW) ? lo_win : '0;
                hi_reg    <= (s_tuser == REQ_WINDOW) ? hi_win : hi0;
                px_reg    <= s_tdata[65:42];
                py_reg    <= s_tdata[89:66];
                found_reg <= 1'b0;
                best_seg_reg <= '0;
                best_cx_reg  <= '0;
                best_cy_reg  <= '0;
                tx_reg    <= UNIT_ONE;
                ty_reg    <= '0;
            end
            ST_RDA: begin
                ax_reg   <= rdata_reg[15:0];
                ay_reg   <= rdata_reg[31:16];
                addr_reg <= seg_reg + IdxW'(1);
            end
            ST_RDB: begin
                bx_reg  <= rdata_reg[15:0];
                by_reg  <= rdata_reg[31:16];
                abx_reg <= 17'($signed(rdata_reg[15:0])) - 17'(ax_reg);
                aby_reg <= 17'($signed(rdata_reg[31:16])) - 17'(ay_reg);
                apx_reg <= 25'(px_reg) - 25'($signed({ax_reg, 8'b0}));
                apy_reg <= 25'(py_reg) - 25'($signed({ay_reg, 8'b0}));
                k_reg   <= '0;
            end
            ST_MUL: begin
                k_reg <= k_reg + 2'd1;
                case (k_reg)
                    2'd0: len_reg <= prod[33:0];
                    2'd1: len_reg <= len_reg + prod[33:0];
                    2'd2: dot_reg <= prod[42:0];
                    default: dot_reg <= dot_reg + prod[42:0];
                endcase
            end
            ST_DECIDE: begin
                k_reg    <= '0;
                axis_reg <= 1'b0;
                if (len_reg == '0 || dot_nonpos) begin
                    cx_reg <= 25'($signed({ax_reg, 8'b0}));
                    cy_reg <= 25'($signed({ay_reg, 8'b0}));
                end else begin
                    cx_reg <= 25'($signed({bx_reg, 8'b0}));
                    cy_reg <= 25'($signed({by_reg, 8'b0}));
                end
            end
            ST_PROD: begin
                k_reg <= k_reg + 2'd1;
                if (k_reg[0]) begin
                    num_reg <= num_reg + (61'(prod) <<< 21);
                end else begin
                    num_reg <= 61'(prod);
                end
            end
            ST_DIVW: begin
                k_reg <= '0;
                if (dsu_stat.done) begin
                    axis_reg <= 1'b1;
                    if (axis_reg) begin
                        cy_reg <= 25'(26'($signed({ay_reg, 8'b0})) + q_signed);
                    end else begin
                        cx_reg <= 25'(26'($signed({ax_reg, 8'b0})) + q_signed);
                    end
                end
            end
            ST_SQ: begin
                k_reg <= k_reg + 2'd1;
                if (k_reg[0]) begin
                    dist_reg <= dist_reg + prod[50:0];
                end else begin
                    dist_reg <= prod[50:0];
                end
            end
            ST_CMP: begin
                if (!found_reg || dist_reg < best_dist_reg) begin
                    found_reg     <= 1'b1;
                    best_dist_reg <= dist_reg;
                    best_seg_reg  <= seg_reg;
                    best_cx_reg   <= cx_reg;
                    best_cy_reg   <= cy_reg;
                    best_abx_reg  <= abx_reg;
                    best_aby_reg  <= aby_reg;
                    best_len_reg  <= len_reg;
                end
                // Next segment starts where this one ends.
                ax_reg   <= bx_reg;
                ay_reg   <= by_reg;
                seg_reg  <= seg_reg + IdxW'(1);
                addr_reg <= seg_reg + IdxW'(2);
                axis_reg <= 1'b0;
            end
            ST_TSQS: begin
                axis_reg <= 1'b0;
                if (best_len_reg == '0) begin
                    tx_reg <= '0;
                    ty_reg <= '0;
                end
            end
            ST_TSQW: begin
                if (dsu_stat.done) begin
                    s_root_reg <= dsu_result;
                end
            end
            ST_TDIVW: begin
                if (dsu_stat.done) begin
                    axis_reg <= 1'b1;
                    if (axis_reg) begin
                        ty_reg <= t_val;
                    end else begin
                        tx_reg <= t_val;
                    end
                end
            end
            default: ;
        endcase
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == ST_DONE && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_DONE && out_free) begin
            m_data_reg <= {5'b0, ty_reg, tx_reg, best_cy_reg[23:0], best_cx_reg[23:0],
                           best_seg_reg, found_reg};
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // The divide/root unit only finishes while the sequencer is waiting for it.
    assert property (@(posedge aclk) disable iff (!aresetn)
        dsu_stat.done |-> (state_reg == ST_DIVW || state_reg == ST_TSQW ||
                           state_reg == ST_TDIVW))
        else $error("divide/root unit finished outside a wait state");

    // A new result appears only out of the completion state.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg == ST_DONE))
        else $error("result raised outside completion");

    // The walk never passes the upper window edge.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MUL) |-> (seg_reg <= hi_reg))
        else $error("segment index beyond window");

    // The unit is never started while still busy.
    assert property (@(posedge aclk) disable iff (!aresetn)
        dsu_ctrl.start |-> !dsu_stat.busy)
        else $error("divide/root unit restarted while busy");

endmodule
`default_nettype wire

FILE: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the nearest polyline segment search core.
// ----------------------------------------------------------------------------
// Polylines are loaded through load beats, then windowed and full-scan
// queries are sent with random positions. A predictor in the scoreboard keeps
// its own copy of the point table and registers and works out the expected
// segment, closest point and tangent for every query, which are compared
// field by field with the result beats. Several polyline sets, counts and
// radii are used, including the extremes, under varied idling on both sides.
// ----------------------------------------------------------------------------

class segment_scoreboard;
    logic [31:0]  pts [0:1023];
    int unsigned  count_reg;
    int unsigned  radius_reg;
    logic [95:0]  pending [$];
    int           mismatches;
    int           results_seen;

    function new();
        count_reg  = 0;
        radius_reg = 5;
        mismatches = 0;
        results_seen = 0;
        foreach (pts[i]) begin
            pts[i] = '0;
        end
    endfunction

    function void write_reg(logic addr, int unsigned val);
        if (addr == npss_pkg::REG_POINT_COUNT)
            count_reg = val & 11'h7ff;
        else
            radius_reg = val & 10'h3ff;
    endfunction

    function longint px_of(int unsigned i);
        return longint'($signed(pts[i][15:0]));
    endfunction

    function longint py_of(int unsigned i);
        return longint'($signed(pts[i][31:16]));
    endfunction

    // Rounded division, halves away from zero, den > 0.
    function longint rdiv(longint num, longint den);
        longint m;
        longint q;
        m = num < 0 ? -num : num;
        q = (2 * m + den) / (2 * den);
        return num < 0 ? -q : q;
    endfunction

    function longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function longint clamp_unit(longint v);
        if (v > 16384) return 16384;
        if (v < -16384) return -16384;
        return v;
    endfunction

    // Notes one accepted input beat and queues the expected result, if any.
    function void note_request(logic [1:0] kind, logic [103:0] d);
        longint unsigned cnt, lo, hi, c, best, bestd, dd, len, s;
        longint px, py, ax, ay, abx, aby, dot, cx, cy, bx, by, tx, ty, dx, dy;
        bit found;
        if (kind == npss_pkg::REQ_LOAD) begin
            pts[d[9:0]] = {d[41:26], d[25:10]};
            return;
        end
        if (kind != npss_pkg::REQ_WINDOW && kind != npss_pkg::REQ_FULL) return;
        cnt = count_reg > 1024 ? 1024 : count_reg;
        px = longint'($signed(d[65:42]));
        py = longint'($signed(d[89:66]));
        found = 0; best = 0; bestd = 0; bx = 0; by = 0; tx = 16384; ty = 0;
        if (cnt >= 2) begin
            hi = cnt - 2;
            lo = 0;
            if (kind == npss_pkg::REQ_WINDOW) begin
                c = d[99:90];
                if (c > hi) c = hi;
                lo = c > radius_reg ? c - radius_reg : 0;
                if (c + radius_reg < hi) hi = c + radius_reg;
            end
            for (longint unsigned i = lo; i <= hi; i++) begin
                ax = px_of(i) * 256;
                ay = py_of(i) * 256;
                abx = px_of(i + 1) - px_of(i);
                aby = py_of(i + 1) - py_of(i);
                len = abx * abx + aby * aby;
                dot = (px - ax) * abx + (py - ay) * aby;
                if (len == 0 || dot <= 0) begin
                    cx = ax; cy = ay;
                end else if (dot >= longint'(len * 256)) begin
                    cx = ax + abx * 256; cy = ay + aby * 256;
                end else begin
                    cx = ax + rdiv(dot * abx, len);
                    cy = ay + rdiv(dot * aby, len);
                end
                dx = px - cx; dy = py - cy;
                dd = dx * dx + dy * dy;
                if (!found || dd < bestd) begin
                    found = 1; bestd = dd; best = i; bx = cx; by = cy;
                end
            end
            abx = px_of(best + 1) - px_of(best);
            aby = py_of(best + 1) - py_of(best);
            len = abx * abx + aby * aby;
            s = int_sqrt(len << 28);
            if (s == 0) begin
                tx = 0; ty = 0;
            end else begin
                tx = clamp_unit(rdiv(abx * (64'sd1 <<< 28), s));
                ty = clamp_unit(rdiv(aby * (64'sd1 <<< 28), s));
            end
        end
        pending.push_back({5'd0, ty[15:0], tx[15:0], by[23:0], bx[23:0],
                           best[9:0], found});
    endfunction

    // Compares one result beat with the oldest expectation.
    function void check_result(logic [95:0] got);
        logic [95:0] exp;
        results_seen++;
        if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("ERROR: unexpected result %h", got);
            return;
        end
        exp = pending.pop_front();
        if (got[0] !== exp[0] || got[10:1] !== exp[10:1] || got[34:11] !== exp[34:11] ||
            got[58:35] !== exp[58:35] || got[74:59] !== exp[74:59] ||
            got[90:75] !== exp[90:75]) begin
            mismatches++;
            if (mismatches <= 10)
                $display("ERROR: result f/seg/cx/cy/tx/ty exp %0d %0d %0d %0d %0d %0d got %0d %0d %0d %0d %0d %0d",
                         exp[0], exp[10:1], $signed(exp[34:11]), $signed(exp[58:35]),
                         $signed(exp[74:59]), $signed(exp[90:75]), got[0], got[10:1],
                         $signed(got[34:11]), $signed(got[58:35]), $signed(got[74:59]),
                         $signed(got[90:75]));
        end
    endfunction
endclass

module tb;
    import npss_pkg::*;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         cfg_wen = 1'b0;
    logic         cfg_addr = 1'b0;
    logic [10:0]  cfg_wdata = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [103:0] s_tdata = '0;
    logic [1:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [95:0]  m_tdata;

    // Idling odds, in percent, for the sender and the receiver.
    int unsigned  send_idle_pct = 0;
    int unsigned  recv_stall_pct = 0;
    int unsigned  queries_sent = 0;
    int unsigned  loads_sent = 0;
    // Number of points currently loaded in a contiguous run from entry 0.
    int unsigned  line_len = 0;

    segment_scoreboard board;

    always #6 aclk = ~aclk;

    nearest_polyline_segment_search_core uut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wen(cfg_wen), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    // The receiver stalls at random; every accepted result beat is checked.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) board.check_result(m_tdata);
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Sends one beat, with an optional random gap ahead of it, and holds it
    // until the block takes it. The scoreboard is told at the accepting edge.
    // Valid stays up afterwards until the next beat, a gap, a drain or a
    // register write replaces or drops it in the same time step.
    task automatic send_beat(logic [1:0] kind, logic [103:0] d);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= d;
        do @(posedge aclk); while (!s_tready);
        board.note_request(kind, d);
        if (kind == REQ_LOAD) loads_sent++;
        else if (kind == REQ_WINDOW || kind == REQ_FULL) queries_sent++;
    endtask

    task automatic load_point(int unsigned idx, logic [15:0] x, logic [15:0] y);
        logic [103:0] d;
        d = 104'({$urandom(), $urandom(), $urandom(), $urandom()});
        d[103:100] = '0;
        d[9:0] = 10'(idx);
        d[25:10] = x;
        d[41:26] = y;
        send_beat(REQ_LOAD, d);
    endtask

    task automatic query(logic [1:0] kind, logic [23:0] x, logic [23:0] y, logic [9:0] seg);
        logic [103:0] d;
        d = 104'({$urandom(), $urandom(), $urandom(), $urandom()});
        d[103:100] = '0;
        d[65:42] = x;
        d[89:66] = y;
        d[99:90] = seg;
        send_beat(kind, d);
    endtask

    // Waits for every expected result, then lets the block settle before any
    // register write, since a load or an ignored beat leaves nothing to wait on.
    task automatic drain();
        int unsigned guard;
        guard = 0;
        s_tvalid <= 1'b0;
        while (board.pending.size() != 0 && guard < 2000000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (200) @(posedge aclk);
    endtask

    task automatic write_reg(logic addr, int unsigned val);
        s_tvalid  <= 1'b0;
        cfg_wen   <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= 11'(val);
        @(posedge aclk);
        board.write_reg(addr, val);
        cfg_wen <= 1'b0;
        @(posedge aclk);
    endtask

    // Coordinates: mostly modest so that queries land near the line, sometimes
    // the full 16-bit range.
    function automatic logic [15:0] rand_coord();
        if ($urandom_range(9) == 0) return 16'($urandom());
        return 16'($signed($urandom_range(400)) - 200);
    endfunction

    function automatic logic [23:0] rand_pos();
        int r;
        r = $urandom_range(9);
        if (r == 0) return 24'($urandom());
        if (r == 1) return $urandom_range(1) ? 24'h800000 : 24'h7fffff;
        return 24'($signed($urandom_range(120000)) - 60000);
    endfunction

    // Loads a fresh polyline of n points into entries 0..n-1.
    task automatic load_line(int unsigned n);
        logic [15:0] x, y;
        x = rand_coord();
        y = rand_coord();
        for (int unsigned i = 0; i < n; i++) begin
            load_point(i, x, y);
            // Repeated points give zero-length segments now and then.
            if ($urandom_range(7) != 0) begin
                x = x + 16'($signed($urandom_range(60)) - 30);
                y = y + 16'($signed($urandom_range(60)) - 30);
            end
        end
        if (n > line_len) line_len = n;
    endtask

    task automatic random_queries(int unsigned n);
        logic [1:0] kind;
        for (int unsigned i = 0; i < n; i++) begin
            case ($urandom_range(19))
                0: begin
                    // Noise: an unknown kind is ignored by the block.
                    query(2'd3, rand_pos(), rand_pos(), 10'($urandom()));
                end
                1: begin
                    // Rewrite an already loaded entry so the table stays defined.
                    if (line_len > 0)
                        load_point($urandom_range(line_len - 1), rand_coord(), rand_coord());
                end
                default: begin
                    kind = ($urandom_range(3) == 0) ? REQ_FULL : REQ_WINDOW;
                    query(kind, rand_pos(), rand_pos(), 10'($urandom()));
                end
            endcase
        end
    endtask

    initial begin
        board = new();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part. With no points loaded every query reports not found.
        query(REQ_FULL, 24'h000000, 24'h000000, 10'd0);
        query(REQ_WINDOW, 24'h7fffff, 24'h800000, 10'd1023);
        // Two points: a single segment, projection before, inside and beyond it.
        load_point(0, 16'd0, 16'd0);
        load_point(1, 16'd100, 16'd0);
        line_len = 2;
        drain();
        write_reg(REG_POINT_COUNT, 1);
        query(REQ_FULL, 24'd1000, 24'd1000, 10'd0);
        drain();
        write_reg(REG_POINT_COUNT, 2);
        write_reg(REG_SEARCH_RADIUS, 0);
        query(REQ_FULL, -24'sd500, 24'd300, 10'd0);
        query(REQ_WINDOW, 24'd12800, 24'd77, 10'd1023);
        query(REQ_WINDOW, 24'd40000, -24'sd90, 10'd0);
        // Extreme coordinates and a zero-length segment.
        load_point(2, 16'h7fff, 16'h8000);
        load_point(3, 16'h8000, 16'h7fff);
        load_point(4, 16'h8000, 16'h7fff);
        line_len = 5;
        drain();
        write_reg(REG_POINT_COUNT, 5);
        write_reg(REG_SEARCH_RADIUS, 1023);
        query(REQ_FULL, 24'h800000, 24'h7fffff, 10'd3);
        query(REQ_WINDOW, 24'h7fffff, 24'h800000, 10'd3);
        query(REQ_WINDOW, -24'sd8388352, 24'd8388352, 10'd1023);
        // Out-of-table loads cannot be expressed in ten bits; an unknown kind is.
        query(2'd3, 24'd0, 24'd0, 10'd0);
        drain();
        // A count above the table size acts as the table size.
        load_line(1024);
        line_len = 1024;
        drain();
        write_reg(REG_POINT_COUNT, 2047);
        query(REQ_FULL, rand_pos(), rand_pos(), 10'd0);
        drain();
        write_reg(REG_POINT_COUNT, 1024);
        write_reg(REG_SEARCH_RADIUS, 3);
        query(REQ_WINDOW, rand_pos(), rand_pos(), 10'd1023);
        query(REQ_WINDOW, rand_pos(), rand_pos(), 10'd0);
        drain();

        // Random phases over several idling modes and settings. Small counts
        // keep full scans short; one phase uses the whole table.
        for (int phase = 0; phase < 8; phase++) begin
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 57; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 57; end
                default: begin send_idle_pct = 18; recv_stall_pct = 18; end
            endcase
            drain();
            if (phase == 7) begin
                write_reg(REG_POINT_COUNT, 1024);
                write_reg(REG_SEARCH_RADIUS, $urandom_range(1, 8));
                random_queries(40);
            end else begin
                line_len = 0;
                load_line($urandom_range(2, 40));
                write_reg(REG_POINT_COUNT, $urandom_range(0, line_len));
                write_reg(REG_SEARCH_RADIUS, (phase == 3) ? 1023 :
                          (phase == 5) ? 0 : $urandom_range(1, 12));
                random_queries(20);
            end
        end

        drain();
        $display("Covered %0d queries and %0d point loads, %0d results checked.",
                 queries_sent, loads_sent, board.results_seen);
        $display("Counts from 0 to the table size, radii 0 to 1023, all idling modes.");
        if (board.mismatches == 0 && board.pending.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("%0d mismatches, %0d results missing", board.mismatches,
                     board.pending.size());
            $display("simulation failed");
        end
        $finish;
    end

    // Overall watchdog: generous for full scans of the whole table.
    initial begin
        #200ms;
        $display("Timeout.");
        $display("simulation failed");
        $finish;
    end
endmodule
